// File: hw/rtl/sse_pkg.sv
`default_nettype none

package sse_pkg;

	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 20;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic signed [KEY_BITS-1:0] key_value;
		logic                       is_last;
	} sse_key_word_t;

	typedef struct packed {
		logic signed [KEY_BITS-1:0] sorted_value;
		logic                       end_of_run;
		logic [COUNT_BITS-1:0]      compare_total;
		logic [COUNT_BITS-1:0]      move_total;
	} sse_res_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/sse_key_ram.sv
`default_nettype none

module sse_key_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/sse_tally.sv
`default_nettype none

module sse_tally (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clear,
	input  wire logic                          bump,
	output logic [sse_pkg::COUNT_BITS-1:0]     count
);
	import sse_pkg::*;

	logic [COUNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (bump && count_q != COUNT_MAX) begin
			count_q <= count_q + COUNT_BITS'(1);
		end
	end

	assign count = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/shell_sort_engine.sv
`default_nettype none

// Collects up to CAPACITY signed keys, one word per cycle, until a word with
// is_last set arrives; key_stall is then held high while the set is sorted
// ascending in place by Shellsort with Knuth gaps (1, 4, 13, ...) and the keys
// are sent out smallest first. Keys beyond CAPACITY are taken and dropped.
// All sort traffic goes through the single read port of the key memory:
// the first gap is found by stepping up the Knuth sequence; each position
// of a pass is fetched and held while larger keys one gap below are shifted
// up until its place or the front of the set is reached; a gap change goes
// through a shrink and a set-gap state; each output key is read, loaded and
// held until taken. The final result word (end_of_run set) carries the
// comparison and move totals of the sort, saturating at 2**20-1; other
// result words carry zero totals. No clearing pass is needed after reset.
module shell_sort_engine #(
	parameter int CAPACITY = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   key_valid,
	output logic                        key_stall,
	input  wire sse_pkg::sse_key_word_t key_data,
	output logic                        res_valid,
	input  wire logic                   res_stall,
	output sse_pkg::sse_res_word_t      res_data
);
	import sse_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int GW = $clog2(3 * CAPACITY + 2);
	localparam int unsigned INV3 = (GW % 2 == 0) ? ((2 ** (GW + 1)) + 1) / 3
	                                             : ((2 ** GW) + 1) / 3;
	localparam logic [GW-1:0] INV3_V = GW'(INV3);

	localparam logic [3:0] ST_LOAD      = 4'd0;
	localparam logic [3:0] ST_GROW      = 4'd1;
	localparam logic [3:0] ST_SHRINK    = 4'd2;
	localparam logic [3:0] ST_SETGAP    = 4'd3;
	localparam logic [3:0] ST_FETCH     = 4'd4;
	localparam logic [3:0] ST_HOLD      = 4'd5;
	localparam logic [3:0] ST_PROBE     = 4'd6;
	localparam logic [3:0] ST_CMP       = 4'd7;
	localparam logic [3:0] ST_EMIT_RD   = 4'd8;
	localparam logic [3:0] ST_EMIT_LD   = 4'd9;
	localparam logic [3:0] ST_EMIT_WAIT = 4'd10;

	logic [3:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [GW-1:0]       gap_q;
	logic [GW-1:0]       gap_div_q;
	logic [AW-1:0]       i_q;
	logic [AW-1:0]       j_q;
	logic [AW-1:0]       k_q;
	logic [KEY_BITS-1:0] held_q;
	logic                out_valid_q;
	sse_res_word_t       out_data_q;

	logic                ram_we;
	logic [AW-1:0]       ram_wr_addr;
	logic [KEY_BITS-1:0] ram_wr_data;
	logic [AW-1:0]       ram_rd_addr;
	logic [KEY_BITS-1:0] ram_rd_data;

	logic                  cmp_bump;
	logic                  mov_bump;
	logic                  tally_clear;
	logic [COUNT_BITS-1:0] cmp_total;
	logic [COUNT_BITS-1:0] mov_total;

	logic                key_take;
	logic                res_take;
	logic [GW-1:0]       j_minus_gap;
	logic                j_reaches;
	logic                shift_up;
	logic [CW-1:0]       i_next;
	logic [GW-1:0]       gap_prod;
	logic                emit_end;

	assign key_take    = key_valid && !key_stall;
	assign res_take    = out_valid_q && !res_stall;
	assign j_minus_gap = GW'(j_q) - gap_q;
	assign j_reaches   = GW'(j_q) >= gap_q;
	assign shift_up    = $signed(ram_rd_data) > $signed(held_q);
	assign i_next      = CW'(i_q) + CW'(1);
	assign gap_prod    = (gap_q - GW'(1)) * INV3_V;
	assign emit_end    = (CW'(k_q) + CW'(1)) == count_q;
	assign tally_clear = key_take && key_data.is_last;

	assign key_stall = state_q != ST_LOAD;
	assign res_valid = out_valid_q;
	assign res_data  = out_data_q;

	// memory port selection
	always_comb begin
		ram_we      = 1'b0;
		ram_wr_addr = j_q;
		ram_wr_data = held_q;
		ram_rd_addr = i_q;
		cmp_bump    = 1'b0;
		mov_bump    = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				ram_we      = key_take && (count_q < CW'(CAPACITY));
				ram_wr_addr = AW'(count_q);
				ram_wr_data = key_data.key_value;
			end
			ST_HOLD: begin
				mov_bump = 1'b1;
			end
			ST_PROBE: begin
				ram_rd_addr = AW'(j_minus_gap);
				if (!j_reaches) begin
					ram_we   = 1'b1;
					cmp_bump = 1'b1;
					mov_bump = 1'b1;
				end
			end
			ST_CMP: begin
				ram_we   = 1'b1;
				cmp_bump = 1'b1;
				mov_bump = 1'b1;
				if (shift_up) begin
					ram_wr_data = ram_rd_data;
				end
			end
			ST_EMIT_RD: begin
				ram_rd_addr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (key_take) begin
						if (count_q < CW'(CAPACITY)) begin
							count_q <= count_q + CW'(1);
						end
						if (key_data.is_last) begin
							state_q <= ST_GROW;
						end
					end
				end
				ST_GROW: begin
					if (gap_q >= GW'(count_q)) begin
						state_q <= ST_SHRINK;
					end
				end
				ST_SHRINK: begin
					if (gap_q > GW'(1)) begin
						state_q <= ST_SETGAP;
					end else begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_SETGAP: begin
					if (gap_div_q < GW'(count_q)) begin
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_SHRINK;
					end
				end
				ST_FETCH: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (j_reaches) begin
						state_q <= ST_CMP;
					end else if (i_next < count_q) begin
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_SHRINK;
					end
				end
				ST_CMP: begin
					if (shift_up) begin
						state_q <= ST_PROBE;
					end else if (i_next < count_q) begin
						state_q <= ST_FETCH;
					end else begin
						state_q <= ST_SHRINK;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (res_take) begin
						out_valid_q <= 1'b0;
						if (out_data_q.end_of_run) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// sort datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				gap_q <= GW'(1);
			end
			ST_GROW: begin
				if (gap_q < GW'(count_q)) begin
					gap_q <= gap_q + gap_q + gap_q + GW'(1);
				end
			end
			ST_SHRINK: begin
				gap_div_q <= gap_prod;
				k_q       <= '0;
			end
			ST_SETGAP: begin
				gap_q <= gap_div_q;
				i_q   <= AW'(gap_div_q);
			end
			ST_HOLD: begin
				held_q <= ram_rd_data;
				j_q    <= i_q;
			end
			ST_PROBE: begin
				if (!j_reaches) begin
					i_q <= AW'(i_next);
				end
			end
			ST_CMP: begin
				if (shift_up) begin
					j_q <= AW'(j_minus_gap);
				end else begin
					i_q <= AW'(i_next);
				end
			end
			ST_EMIT_LD: begin
				out_data_q.sorted_value  <= $signed(ram_rd_data);
				out_data_q.end_of_run    <= emit_end;
				out_data_q.compare_total <= emit_end ? cmp_total : '0;
				out_data_q.move_total    <= emit_end ? mov_total : '0;
			end
			ST_EMIT_WAIT: begin
				if (res_take) begin
					k_q <= k_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	sse_key_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (KEY_BITS),
		.AW    (AW)
	) u_key_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sse_tally u_cmp_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (tally_clear),
		.bump   (cmp_bump),
		.count  (cmp_total)
	);

	sse_tally u_mov_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (tally_clear),
		.bump   (mov_bump),
		.count  (mov_total)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall && key_data.is_last |=> key_stall)
		else $error("input not stalled after last key");

	a_valid_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_EMIT_WAIT)
		else $error("result valid outside emission");

	a_probe_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> CW'(j_q) < count_q)
		else $error("probe index beyond loaded set");

endmodule

`default_nettype wire
